[design/morse_keyer_from_ascii_macros.svh]
// ----------------------------------------------------------------------------
// morse_keyer_from_ascii_macros.svh
// assertion macros used by the keyer top-level design file
// ----------------------------------------------------------------------------
`ifndef MORSE_KEYER_FROM_ASCII_MACROS_SVH
`define MORSE_KEYER_FROM_ASCII_MACROS_SVH

`ifndef NO_ASSERTIONS

// check clocked on clk, switched off while reset is held
`define MKEY_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check clocked on clk that also holds through reset
`define MKEY_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MKEY_ASSERT(lbl, prop, msg)
`define MKEY_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[design/mkey_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkey_pkg
// types, character codes and morse tables for the ascii morse keyer
// ----------------------------------------------------------------------------
package mkey_pkg;

    localparam int MAX_CMD_CHARS_DEF = 7;

    localparam logic [15:0] UNIT_RESET = 16'd200;
    localparam logic [15:0] MIN_UNIT_RESET = 16'd20;

    localparam int TIMER_W = 18;
    localparam int OUT_W = 32;

    // character codes
    localparam logic [7:0] CH_DELIM = 8'h5C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;

    // configuration register indexes
    localparam logic CFG_MIN_UNIT = 1'b0;
    localparam logic CFG_ECHO_EN = 1'b1;

    // result beat bit positions
    localparam int OB_LED = 0;
    localparam int OB_TAKEN = 1;
    localparam int OB_ECHO_V = 2;
    localparam int OB_ECHO_LO = 3;
    localparam int OB_ECHO_HI = 10;
    localparam int OB_UPD = 11;
    localparam int OB_UNIT_LO = 12;
    localparam int OB_UNIT_HI = 27;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_SPACE = 2'd2,
        MODE_PARSE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_ON     = 2'd0,
        PH_GAP    = 2'd1,
        PH_LETTER = 2'd2
    } phase_t;

    typedef struct packed {
        logic       action;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic        led_on;
        logic        char_taken;
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic        unit_updated;
        logic [15:0] unit_value;
    } result_t;

    // length in [7:5], pattern in [4:0], first element in bit 0, 1 = dash
    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = {3'd2, 5'd2};
            5'd1:    c = {3'd4, 5'd1};
            5'd2:    c = {3'd4, 5'd5};
            5'd3:    c = {3'd3, 5'd1};
            5'd4:    c = {3'd1, 5'd0};
            5'd5:    c = {3'd4, 5'd4};
            5'd6:    c = {3'd3, 5'd3};
            5'd7:    c = {3'd4, 5'd0};
            5'd8:    c = {3'd2, 5'd0};
            5'd9:    c = {3'd4, 5'd14};
            5'd10:   c = {3'd3, 5'd5};
            5'd11:   c = {3'd4, 5'd2};
            5'd12:   c = {3'd2, 5'd3};
            5'd13:   c = {3'd2, 5'd1};
            5'd14:   c = {3'd3, 5'd7};
            5'd15:   c = {3'd4, 5'd6};
            5'd16:   c = {3'd4, 5'd11};
            5'd17:   c = {3'd3, 5'd2};
            5'd18:   c = {3'd3, 5'd0};
            5'd19:   c = {3'd1, 5'd1};
            5'd20:   c = {3'd3, 5'd4};
            5'd21:   c = {3'd4, 5'd8};
            5'd22:   c = {3'd3, 5'd6};
            5'd23:   c = {3'd4, 5'd9};
            5'd24:   c = {3'd4, 5'd13};
            5'd25:   c = {3'd4, 5'd3};
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] digit_code(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = {3'd5, 5'd31};
            4'd1:    c = {3'd5, 5'd30};
            4'd2:    c = {3'd5, 5'd28};
            4'd3:    c = {3'd5, 5'd24};
            4'd4:    c = {3'd5, 5'd16};
            4'd5:    c = {3'd5, 5'd0};
            4'd6:    c = {3'd5, 5'd1};
            4'd7:    c = {3'd5, 5'd3};
            4'd8:    c = {3'd5, 5'd7};
            4'd9:    c = {3'd5, 5'd15};
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

[design/mkey_in_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkey_in_stage
// input register: holds one accepted beat until the engine consumes it
// ----------------------------------------------------------------------------
module mkey_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] char_in
    input  logic                s_tuser,   // [0] action
    input  logic                pop,
    output logic                item_valid,
    output mkey_pkg::item_t     item
);
    import mkey_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // free slot, or the held beat leaves this cycle
    assign s_tready = !valid_reg || pop;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= '{action: s_tuser, ch: s_tdata};
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

[design/mkey_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkey_engine
// keyer state, configuration registers and the per-beat next-state logic
// ----------------------------------------------------------------------------
module mkey_engine
#(
    parameter int MAX_CMD_CHARS = mkey_pkg::MAX_CMD_CHARS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                step,
    input  mkey_pkg::item_t     item,
    output mkey_pkg::result_t   result
);
    import mkey_pkg::*;

    localparam int CW = $clog2(MAX_CMD_CHARS + 1);

    logic [15:0]        min_unit_reg;
    logic               echo_en_reg;

    mode_t              mode_reg, mode_next;
    phase_t             phase_reg, phase_next;
    logic [15:0]        dot_reg, dot_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [4:0]         bits_reg, bits_next;
    logic [2:0]         left_reg, left_next;
    logic [7:0]         pend_reg, pend_next;
    logic [15:0]        pv_reg, pv_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               open_reg, open_next;

    logic [TIMER_W-1:0] dot1, dot3, dot4;
    logic [15:0]        lo_unit, pv_final;
    logic [19:0]        pv_mul;
    logic [15:0]        pv_sat;
    logic [7:0]         code;
    logic               has_code, done, finish;
    logic               taken, echo_v, updated;
    logic [7:0]         echo_b;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_unit_reg <= MIN_UNIT_RESET;
            echo_en_reg  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_UNIT: min_unit_reg <= cfg_data;
                CFG_ECHO_EN:  echo_en_reg  <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // keyer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= PH_GAP;
            dot_reg   <= UNIT_RESET;
            timer_reg <= '0;
            bits_reg  <= '0;
            left_reg  <= '0;
            pend_reg  <= '0;
            pv_reg    <= '0;
            cnt_reg   <= '0;
            open_reg  <= 1'b1;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            dot_reg   <= dot_next;
            timer_reg <= timer_next;
            bits_reg  <= bits_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
            pv_reg    <= pv_next;
            cnt_reg   <= cnt_next;
            open_reg  <= open_next;
        end
    end

    // unit multiples and the decimal accumulator
    always_comb
    begin
        dot1 = {2'b00, dot_reg};
        dot3 = {2'b00, dot_reg} + {1'b0, dot_reg, 1'b0};
        dot4 = {dot_reg, 2'b00};
        lo_unit = (min_unit_reg == 16'd0) ? 16'd1 : min_unit_reg;
        pv_mul = {1'b0, pv_reg, 3'b000} + {3'b000, pv_reg, 1'b0} + {16'd0, item.ch[3:0]};
        pv_sat = (pv_mul[19:16] != 4'd0) ? 16'hFFFF : pv_mul[15:0];
    end

    // next state and result for the beat in the input register
    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        dot_next   = dot_reg;
        timer_next = timer_reg;
        bits_next  = bits_reg;
        left_next  = left_reg;
        pend_next  = pend_reg;
        pv_next    = pv_reg;
        cnt_next   = cnt_reg;
        open_next  = open_reg;
        taken      = 1'b0;
        echo_v     = 1'b0;
        echo_b     = 8'd0;
        updated    = 1'b0;
        done       = 1'b0;
        finish     = 1'b0;
        has_code   = 1'b0;
        code       = 8'd0;
        pv_final   = pv_reg;

        if (!item.action)
        begin
            // millisecond tick
            if (mode_reg == MODE_KEY || mode_reg == MODE_SPACE)
            begin
                timer_next = timer_reg - 1'b1;
                if (timer_next == '0)
                begin
                    if (mode_reg == MODE_SPACE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_ON:
                            begin
                                phase_next = PH_GAP;
                                timer_next = dot1;
                            end
                            PH_GAP:
                            begin
                                if (left_reg != 3'd0)
                                begin
                                    timer_next = bits_reg[0] ? dot3 : dot1;
                                    phase_next = PH_ON;
                                    bits_next  = {1'b0, bits_reg[4:1]};
                                    left_next  = left_reg - 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_LETTER;
                                    timer_next = dot3;
                                end
                            end
                            default:
                            begin
                                done = 1'b1;
                            end
                        endcase
                    end
                    if (done)
                    begin
                        mode_next  = MODE_IDLE;
                        phase_next = PH_GAP;
                        echo_v     = 1'b1;
                        echo_b     = pend_reg;
                    end
                end
            end
        end
        else if (mode_reg == MODE_PARSE)
        begin
            // character inside a delay command
            taken = 1'b1;
            if (item.ch == CH_DELIM)
            begin
                finish = 1'b1;
            end
            else
            begin
                if (open_reg && (item.ch inside {[CH_0:CH_9]}))
                begin
                    pv_final = pv_sat;
                end
                else
                begin
                    open_next = 1'b0;
                end
                pv_next  = pv_final;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_next >= CW'(MAX_CMD_CHARS))
                begin
                    finish = 1'b1;
                end
            end
            if (finish)
            begin
                dot_next  = (pv_final < lo_unit) ? lo_unit : pv_final;
                mode_next = MODE_IDLE;
                pv_next   = '0;
                cnt_next  = '0;
                open_next = 1'b1;
                updated   = 1'b1;
            end
        end
        else if (mode_reg == MODE_IDLE)
        begin
            // character while idle
            taken = 1'b1;
            if (item.ch == CH_DELIM)
            begin
                mode_next = MODE_PARSE;
                pv_next   = '0;
                cnt_next  = '0;
                open_next = 1'b1;
            end
            else if (item.ch inside {[CH_LA:CH_LZ]})
            begin
                code     = letter_code(5'(item.ch - CH_LA));
                has_code = 1'b1;
            end
            else if (item.ch inside {[CH_UA:CH_UZ]})
            begin
                code     = letter_code(5'(item.ch - CH_UA));
                has_code = 1'b1;
            end
            else if (item.ch inside {[CH_0:CH_9]})
            begin
                code     = digit_code(item.ch[3:0]);
                has_code = 1'b1;
            end
            else if (item.ch == CH_SPACE)
            begin
                mode_next  = MODE_SPACE;
                timer_next = dot4;
                pend_next  = item.ch;
            end
            else
            begin
                echo_v = 1'b1;
                echo_b = CH_DASH;
            end
            if (has_code)
            begin
                mode_next  = MODE_KEY;
                pend_next  = item.ch;
                timer_next = code[0] ? dot3 : dot1;
                phase_next = PH_ON;
                bits_next  = {1'b0, code[4:1]};
                left_next  = code[7:5] - 1'b1;
            end
        end

        if (!echo_en_reg)
        begin
            echo_v = 1'b0;
            echo_b = 8'd0;
        end

        result.led_on       = (mode_next == MODE_KEY) && (phase_next == PH_ON);
        result.char_taken   = taken;
        result.echo_valid   = echo_v;
        result.echo_byte    = echo_b;
        result.unit_updated = updated;
        result.unit_value   = dot_next;
    end

endmodule

[design/mkey_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkey_out_reg
// result register: packs one result into a beat and holds it until taken
// ----------------------------------------------------------------------------
module mkey_out_reg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  mkey_pkg::result_t           result,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] led_on, [1] char_taken, [2] echo_valid, [10:3] echo_byte,
    // [11] unit_updated, [27:12] unit_value, [31:28] zero
    output logic [mkey_pkg::OUT_W-1:0]  m_tdata
);
    import mkey_pkg::*;

    logic             valid_reg;
    logic [OUT_W-1:0] data_reg;

    // valid flag: set on load, cleared once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // packed result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {4'b0000, result.unit_value, result.unit_updated,
                         result.echo_byte, result.echo_valid, result.char_taken,
                         result.led_on};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;

endmodule

[design/morse_keyer_from_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_keyer_from_ascii: ascii characters and ms ticks keyed as morse code
// path: each input beat passes through the input reg and the result reg to its result beat
// throughput: 1 beat per cycle while the result side is not stalled, one state update per beat
// reset: async active low, unit 200 ms, minimum 20 ms, echo on, keyer idle
// ----------------------------------------------------------------------------
`include "morse_keyer_from_ascii_macros.svh"

module morse_keyer_from_ascii
#(
    parameter int MAX_CMD_CHARS = mkey_pkg::MAX_CMD_CHARS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] char_in
    input  logic                        s_tuser,   // [0] action
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] led_on, [1] char_taken, [2] echo_valid, [10:3] echo_byte,
    // [11] unit_updated, [27:12] unit_value, [31:28] zero
    output logic [mkey_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [15:0]                 cfg_data
);
    import mkey_pkg::*;

    logic    item_valid;
    item_t   item;
    result_t result;
    logic    advance;

    // the held beat moves on when the result register is free or draining
    assign advance = item_valid && (!m_tvalid || m_tready);
    assign cfg_ready = 1'b1;

    mkey_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .pop        (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mkey_engine #(
        .MAX_CMD_CHARS (MAX_CMD_CHARS)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item      (item),
        .result    (result)
    );

    mkey_out_reg u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // an empty result register never stalls the input side
    `MKEY_ASSERT(a_ready_when_out_free, !m_tvalid |-> s_tready, "input stalled with free output")
    // a completed delay command always consumed its character
    `MKEY_ASSERT(a_update_is_taken, (m_tvalid && m_tdata[OB_UPD]) |-> m_tdata[OB_TAKEN], "unit update without taken char")
    // echo byte reads zero unless flagged
    `MKEY_ASSERT(a_echo_zero, (m_tvalid && !m_tdata[OB_ECHO_V]) |-> (m_tdata[OB_ECHO_HI:OB_ECHO_LO] == 8'd0), "stray echo byte")
    // dot unit can never be zero
    `MKEY_ASSERT_ALWAYS(a_unit_nonzero, m_tvalid |-> (m_tdata[OB_UNIT_HI:OB_UNIT_LO] != 16'd0), "zero dot unit")

endmodule
